FILE: hdl/lslt_pkg.sv
// ----------------------------------------------------------------------------
// lslt_pkg
// Types and constants shared by the segment layout and translate block.
// ----------------------------------------------------------------------------
`default_nettype none

package lslt_pkg;

  localparam int unsigned MaxSegmentsDef = 16;
  localparam logic [4:0]  PageShiftRst   = 5'd12;
  localparam logic [31:0] SegTypeLoad    = 32'd1;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_LOAD      = 2'd1,
    OP_TRANSLATE = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic {
    KIND_LAYOUT    = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] seg_type;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_memsz;
    logic [63:0] seg_filesz;
    logic [63:0] seg_file_offset;
    logic        last_segment;
    logic [63:0] query_vaddr;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        layout_valid;
    logic [63:0] min_vaddr;
    logic [63:0] map_size;
    logic        hit;
    logic [63:0] file_offset;
    logic        table_overflow;
  } out_item_t;

  // One table row. end_addr is start + file size (mod 2^64), bias is
  // offset - start (mod 2^64), so a lookup needs two compares and one add.
  typedef struct packed {
    logic        is_load;
    logic [63:0] start;
    logic [63:0] end_addr;
    logic [63:0] bias;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/lslt_ram.sv
// ----------------------------------------------------------------------------
// lslt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lslt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/load_segment_layout_and_translate_top.sv
// ----------------------------------------------------------------------------
// load_segment_layout_and_translate_top
// Segment table with load layout tracking and address to file offset lookup.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------
//  in      | in  | in_valid_i / in_ready_o   | in_data_i   (in_item_t)
//  out     | out | out_valid_o / out_ready_i | out_data_o  (out_item_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i  (page shift)
//
//  Clear, plain load and unused op complete in S_IDLE. A last load then goes
//  through S_ROUND for page rounding. A translate reads one table row per cycle
//  from the RAM, scanning rows up to the first hit (at most entry count).
//  Reset clears counters and layout bounds; RAM rows are read only below the
//  fill count. A finished result waits in the output register; the block
//  stalls only when the next result is ready and that register is still full.

`default_nettype none

module load_segment_layout_and_translate_top #(
  parameter int unsigned MAX_SEGMENTS = lslt_pkg::MaxSegmentsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire lslt_pkg::in_item_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      lslt_pkg::out_item_t out_data_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [4:0]          cfg_data_i
);

  import lslt_pkg::*;

  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EntW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_LAYOUT,
    S_SCAN,
    S_XLATE
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  page_shift_q, page_shift_d;
  logic [CntW-1:0] count_q, count_d;
  logic [63:0] low_q, low_d;
  logic [63:0] high_q, high_d;
  logic        sum_ovf_q, sum_ovf_d;
  logic        dropped_q, dropped_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [63:0] query_q, query_d;
  logic        hit_q, hit_d;
  logic [63:0] off_q, off_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] hi_q, hi_d;
  logic        valid_q, valid_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        in_acc;
  logic        slot_free;
  logic        ram_we, ram_re;
  logic [IdxW-1:0] ram_raddr;
  entry_t      wr_entry, rd_entry;
  logic        seg_is_load;
  logic [64:0] mem_end;
  logic [63:0] page_mask;
  logic        rd_hit;
  logic        last_row;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  assign seg_is_load = (in_data_i.seg_type == SegTypeLoad);
  assign mem_end     = {1'b0, in_data_i.seg_vaddr} + {1'b0, in_data_i.seg_memsz};

  assign wr_entry.is_load  = seg_is_load;
  assign wr_entry.start    = in_data_i.seg_vaddr;
  assign wr_entry.end_addr = in_data_i.seg_vaddr + in_data_i.seg_filesz;
  assign wr_entry.bias     = in_data_i.seg_file_offset - in_data_i.seg_vaddr;

  assign ram_we = in_acc && (op_e'(in_data_i.operation) == OP_LOAD) &&
                  (count_q < CntW'(MAX_SEGMENTS));

  assign page_mask = ~((64'd1 << page_shift_q) - 64'd1);

  // Wrapped ranges have end below start and so never match.
  assign rd_hit   = rd_entry.is_load && (query_q >= rd_entry.start) &&
                    (query_q < rd_entry.end_addr);
  assign last_row = ((CntW'(idx_q) + CntW'(1)) == count_q);

  lslt_ram #(
    .Width (EntW),
    .Depth (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d      = state_q;
    page_shift_d = page_shift_q;
    count_d      = count_q;
    low_d        = low_q;
    high_d       = high_q;
    sum_ovf_d    = sum_ovf_q;
    dropped_d    = dropped_q;
    idx_d        = idx_q;
    query_d      = query_q;
    hit_d        = hit_q;
    off_d        = off_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    if (cfg_valid_i) begin
      page_shift_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e'(in_data_i.operation))
            OP_CLEAR: begin
              count_d   = '0;
              low_d     = '1;
              high_d    = '0;
              sum_ovf_d = 1'b0;
              dropped_d = 1'b0;
            end
            OP_LOAD: begin
              if (ram_we) begin
                count_d = count_q + CntW'(1);
                if (seg_is_load) begin
                  if (in_data_i.seg_vaddr < low_q) begin
                    low_d = in_data_i.seg_vaddr;
                  end
                  if (mem_end[64]) begin
                    sum_ovf_d = 1'b1;
                  end else if (mem_end[63:0] > high_q) begin
                    high_d = mem_end[63:0];
                  end
                end
              end else begin
                dropped_d = 1'b1;
              end
              if (in_data_i.last_segment) begin
                state_d = S_ROUND;
              end
            end
            OP_TRANSLATE: begin
              query_d   = in_data_i.query_vaddr;
              hit_d     = 1'b0;
              off_d     = '0;
              idx_d     = '0;
              ram_raddr = '0;
              if (count_q == '0) begin
                state_d = S_XLATE;
              end else begin
                ram_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROUND: begin
        valid_d = !sum_ovf_q && (high_q > low_q);
        lo_d    = low_q & page_mask;
        hi_d    = (high_q + ~page_mask) & page_mask;
        state_d = S_LAYOUT;
      end
      S_LAYOUT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.result_kind    = KIND_LAYOUT;
          out_d.layout_valid   = valid_q;
          out_d.min_vaddr      = valid_q ? lo_q : '0;
          out_d.map_size       = valid_q ? (hi_q - lo_q) : '0;
          out_d.table_overflow = dropped_q;
          state_d              = S_IDLE;
        end
      end
      S_SCAN: begin
        // rd_entry holds row idx_q
        if (rd_hit) begin
          hit_d   = 1'b1;
          off_d   = rd_entry.bias + query_q;
          state_d = S_XLATE;
        end else if (last_row) begin
          state_d = S_XLATE;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          ram_raddr = idx_q + IdxW'(1);
          ram_re    = 1'b1;
        end
      end
      S_XLATE: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.result_kind    = KIND_TRANSLATE;
          out_d.hit            = hit_q;
          out_d.file_offset    = off_q;
          out_d.table_overflow = dropped_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      page_shift_q <= PageShiftRst;
      count_q      <= '0;
      low_q        <= '1;
      high_q       <= '0;
      sum_ovf_q    <= 1'b0;
      dropped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      query_q      <= '0;
      hit_q        <= 1'b0;
      off_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      valid_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      page_shift_q <= page_shift_d;
      count_q      <= count_d;
      low_q        <= low_d;
      high_q       <= high_d;
      sum_ovf_q    <= sum_ovf_d;
      dropped_q    <= dropped_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      query_q      <= query_d;
      hit_q        <= hit_d;
      off_q        <= off_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      valid_q      <= valid_d;
      out_q        <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives program header loads, table clears and address lookups into the
// segment layout block and checks every layout and lookup result against an
// in-bench model of the segment table, across several page shift settings,
// with random idle cycles on the input and random stalls on the output.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lslt_pkg::*;

  localparam int unsigned MaxSegments  = MaxSegmentsDef;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned PhaseItems   = 100;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  in_item_t   in_data     = '0;
  logic       out_ready   = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic [4:0] cfg_data    = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  out_item_t  out_data_o;
  logic       cfg_ready_o;

  // Handshake flags captured at the rising edge, used at the falling edge
  logic in_accepted  = 1'b0;
  logic out_accepted = 1'b0;
  logic cfg_accepted = 1'b0;

  in_item_t    pending_items[$];
  out_item_t   awaited_results[$];
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_gap = 0, in_calm = 0, out_gap = 0, out_calm = 0;

  // Segment table model
  logic        seg_is_load[MaxSegments];
  logic [63:0] tbl_start[MaxSegments];
  logic [63:0] seg_fsz[MaxSegments];
  logic [63:0] seg_off[MaxSegments];
  int unsigned seg_count;
  logic [63:0] lo_bound;
  logic [63:0] hi_bound;
  logic        sum_wrapped;
  logic        entries_dropped;
  logic [4:0]  shift_model = PageShiftRst;

  // Loaded ranges, kept only to aim lookups at them
  logic [63:0] aim_start[$];
  logic [63:0] aim_size[$];

  load_segment_layout_and_translate_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_segment_table();
    for (int i = 0; i < MaxSegments; i++) begin
      seg_is_load[i] = 1'b0;
    end
    seg_count       = 0;
    lo_bound        = '1;
    hi_bound        = '0;
    sum_wrapped     = 1'b0;
    entries_dropped = 1'b0;
  endfunction

  // Updates the table model for one accepted transaction and records the
  // result it should produce, if any.
  function automatic void apply_segment_item(in_item_t it);
    out_item_t   r;
    logic [64:0] end_sum;
    logic [63:0] mask;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] seg_end;
    int unsigned i;
    r = '0;
    case (op_e'(it.operation))
      OP_CLEAR: reset_segment_table();
      OP_LOAD: begin
        if (seg_count < MaxSegments) begin
          seg_is_load[seg_count] = (it.seg_type == SegTypeLoad);
          tbl_start[seg_count]   = it.seg_vaddr;
          seg_fsz[seg_count]     = it.seg_filesz;
          seg_off[seg_count]     = it.seg_file_offset;
          if (seg_is_load[seg_count]) begin
            end_sum = {1'b0, it.seg_vaddr} + {1'b0, it.seg_memsz};
            if (it.seg_vaddr < lo_bound) lo_bound = it.seg_vaddr;
            if (end_sum[64]) sum_wrapped = 1'b1;
            else if (end_sum[63:0] > hi_bound) hi_bound = end_sum[63:0];
          end
          seg_count++;
        end else begin
          entries_dropped = 1'b1;
        end
        if (it.last_segment) begin
          r.result_kind  = KIND_LAYOUT;
          r.layout_valid = !sum_wrapped && (hi_bound > lo_bound);
          mask = ~((64'd1 << shift_model) - 64'd1);
          if (r.layout_valid) begin
            lo = lo_bound & mask;
            hi = (hi_bound + ~mask) & mask;  // may wrap to zero
            r.min_vaddr = lo;
            r.map_size  = hi - lo;
          end
          r.table_overflow = entries_dropped;
          awaited_results.push_back(r);
        end
      end
      OP_TRANSLATE: begin
        r.result_kind = KIND_TRANSLATE;
        for (i = 0; i < seg_count; i++) begin
          seg_end = tbl_start[i] + seg_fsz[i];
          if (!r.hit && seg_is_load[i] && it.query_vaddr >= tbl_start[i] &&
              it.query_vaddr < seg_end) begin
            r.hit         = 1'b1;
            r.file_offset = seg_off[i] + (it.query_vaddr - tbl_start[i]);
          end
        end
        r.table_overflow = entries_dropped;
        awaited_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%h, got 0x%h", $time, field, want, got);
    end
  endfunction

  // Idle cycles before the next transaction, with the odd run of none at all
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Every field random, so unused fields toggle too
  function automatic in_item_t random_item(op_e op);
    in_item_t it;
    it.operation       = op;
    it.seg_type        = $urandom;
    it.seg_vaddr       = {$urandom, $urandom};
    it.seg_memsz       = {$urandom, $urandom};
    it.seg_filesz      = {$urandom, $urandom};
    it.seg_file_offset = {$urandom, $urandom};
    it.last_segment    = 1'($urandom_range(0, 1));
    it.query_vaddr     = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void enqueue(in_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_op(op_e op);
    if (op == OP_CLEAR) begin
      aim_start.delete();
      aim_size.delete();
    end
    enqueue(random_item(op));
  endfunction

  function automatic void queue_load(logic [31:0] kind, logic [63:0] vaddr, logic [63:0] memsz,
                                     logic [63:0] filesz, logic [63:0] foff, logic last);
    in_item_t it;
    it = random_item(OP_LOAD);
    it.seg_type        = kind;
    it.seg_vaddr       = vaddr;
    it.seg_memsz       = memsz;
    it.seg_filesz      = filesz;
    it.seg_file_offset = foff;
    it.last_segment    = last;
    aim_start.push_back(vaddr);
    aim_size.push_back(filesz);
    enqueue(it);
  endfunction

  function automatic void queue_lookup(logic [63:0] query);
    in_item_t it;
    it = random_item(OP_TRANSLATE);
    it.query_vaddr = query;
    enqueue(it);
  endfunction

  // A load run closed by a last entry, then lookups aimed mostly at the
  // loaded ranges and their edges, with some noise after.
  function automatic void queue_load_run(int unsigned n);
    logic [31:0] kind;
    logic [63:0] vaddr, memsz, filesz, foff, q;
    int unsigned k, j, lookups;
    if ($urandom_range(0, 3) != 0) queue_op(OP_CLEAR);
    for (k = 0; k < n; k++) begin
      kind  = ($urandom_range(0, 4) != 0) ? SegTypeLoad : $urandom;
      vaddr = ($urandom_range(0, 5) != 0) ?
              64'h40_0000 + {$urandom_range(0, 1023), 12'h0} + $urandom_range(0, 4095) :
              {$urandom, $urandom};
      memsz  = ($urandom_range(0, 9) != 0) ? 64'($urandom_range(0, 32'h9000)) :
               {$urandom, $urandom};
      filesz = ($urandom_range(0, 9) != 0) ? 64'($urandom_range(0, 32'h6000)) :
               {$urandom, $urandom};
      foff   = $urandom_range(0, 1) ? 64'($urandom_range(0, 32'hF_FFFF)) :
               {$urandom, $urandom};
      queue_load(kind, vaddr, memsz, filesz, foff, k == n - 1);
    end
    lookups = $urandom_range(1, 6);
    for (k = 0; k < lookups; k++) begin
      if (aim_start.size() != 0 && $urandom_range(0, 3) != 0) begin
        j = $urandom_range(0, aim_start.size() - 1);
        case ($urandom_range(0, 3))
          0:       q = aim_start[j];
          1:       q = aim_start[j] + aim_size[j] - 64'd1;
          2:       q = aim_start[j] + aim_size[j];
          default: q = aim_start[j] +
                       ((aim_size[j] == 0) ? 64'd0 : {$urandom, $urandom} % aim_size[j]);
        endcase
      end else begin
        q = {$urandom, $urandom};
      end
      queue_lookup(q);
    end
    if ($urandom_range(0, 9) == 0) queue_op(OP_NONE);
    if ($urandom_range(0, 9) == 0) begin
      queue_load($urandom, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic drain_block();
    do @(negedge clk_i);
    while (items_accepted != items_queued || awaited_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_page_shift(logic [4:0] shift);
    @(negedge clk_i);
    cfg_data  <= shift;
    cfg_valid <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_accepted);
    cfg_valid <= 1'b0;
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_accepted)) begin
      if (in_valid) in_gap = draw_gap(in_calm);
      if (in_gap == 0 && pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end
    end
  end

  // Result receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_accepted) out_gap = draw_gap(out_calm);
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i) begin : watch_ports
    out_item_t want;
    in_accepted  <= rst_ni && in_valid && in_ready_o;
    out_accepted <= rst_ni && out_valid_o && out_ready;
    cfg_accepted <= rst_ni && cfg_valid && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) shift_model = cfg_data;
      if (out_valid_o && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, got %p", $time, out_data_o);
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", want.result_kind, out_data_o.result_kind);
          check_field("layout_valid", want.layout_valid, out_data_o.layout_valid);
          check_field("min_vaddr", want.min_vaddr, out_data_o.min_vaddr);
          check_field("map_size", want.map_size, out_data_o.map_size);
          check_field("hit", want.hit, out_data_o.hit);
          check_field("file_offset", want.file_offset, out_data_o.file_offset);
          check_field("table_overflow", want.table_overflow, out_data_o.table_overflow);
        end
      end
      // result of a transaction cannot leave on the edge that takes it in
      if (in_valid && in_ready_o) begin
        apply_segment_item(in_data);
        items_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0]  shift_plan[4];
    int unsigned target;
    reset_segment_table();
    shift_plan = '{5'd0, 5'd31, 5'd16, 5'd12};
    shift_plan[3] = 5'($urandom_range(13, 15));
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset page shift
    queue_lookup(64'h0);                                      // empty table
    queue_op(OP_NONE);
    queue_load(32'd0, 64'h1000, 64'h1000, 64'h1000, 64'h0, 1'b1);  // nothing loadable
    queue_op(OP_CLEAR);
    queue_load(SegTypeLoad, 64'h40_1234, 64'h3000, 64'h2000, 64'h1234, 1'b0);
    queue_load(32'hFFFF_FFFF, 64'h0, 64'h10, '1, 64'h0, 1'b0);
    // file range wraps; rounded high end wraps to zero
    queue_load(SegTypeLoad, 64'hFFFF_FFFF_FFFF_E000, 64'h1800, 64'h4000,
               64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
    queue_lookup(64'h40_1234);
    queue_lookup(64'h40_3233);
    queue_lookup(64'h40_3234);
    queue_lookup(64'h40_1233);
    queue_lookup(64'hFFFF_FFFF_FFFF_F000);
    queue_lookup(64'h8);                                      // only a non-loadable row
    queue_load(SegTypeLoad, 64'h10, 64'h0, 64'h100, '1, 1'b1);
    queue_lookup(64'h20);                                     // offset wraps
    queue_op(OP_CLEAR);
    queue_load(SegTypeLoad, '1, 64'h1, 64'h0, 64'h0, 1'b1);   // end overflows
    queue_lookup('1);
    queue_op(OP_CLEAR);
    queue_load(SegTypeLoad, 64'h5000, 64'h0, 64'h10, 64'h0, 1'b1);  // high equals low
    queue_lookup(64'h5008);
    queue_op(OP_CLEAR);
    drain_block();

    for (int p = 0; p < 4; p++) begin
      write_page_shift(shift_plan[p]);
      if (p == 0) queue_load_run(MaxSegments + 2);  // overfill the table
      target = items_queued + PhaseItems;
      while (items_queued < target) begin
        queue_load_run(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) :
                       $urandom_range(1, 6));
      end
      drain_block();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
